/* design/sbt_pkg.sv */
// Shared types, codes and character tables for the source byte tokenizer.
package sbt_pkg;

  localparam int POSITION_WIDTH_DEF = 24;
  localparam int LENGTH_WIDTH_DEF   = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam int KIND_W = 3;
  localparam int OP_W   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOLLAR = 3'd0,
    KIND_BODY   = 3'd1,
    KIND_PARAM  = 3'd2,
    KIND_OP     = 3'd3,
    KIND_IDENT  = 3'd4,
    KIND_NUMBER = 3'd5,
    KIND_ERROR  = 3'd6,
    KIND_END    = 3'd7
  } token_kind_t;

  localparam logic [OP_W-1:0] OP_PLUS  = 4'd0;
  localparam logic [OP_W-1:0] OP_MINUS = 4'd1;
  localparam logic [OP_W-1:0] OP_STAR  = 4'd2;
  localparam logic [OP_W-1:0] OP_SLASH = 4'd3;
  localparam logic [OP_W-1:0] OP_CARET = 4'd4;
  localparam logic [OP_W-1:0] OP_LPAR  = 4'd5;
  localparam logic [OP_W-1:0] OP_RPAR  = 4'd6;
  localparam logic [OP_W-1:0] OP_ASSIGN = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ    = 4'd8;
  localparam logic [OP_W-1:0] OP_LT    = 4'd9;
  localparam logic [OP_W-1:0] OP_LE    = 4'd10;
  localparam logic [OP_W-1:0] OP_GT    = 4'd11;
  localparam logic [OP_W-1:0] OP_GE    = 4'd12;
  localparam logic [OP_W-1:0] OP_NE    = 4'd13;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_BODY   = 4'd1,
    S_PARAM  = 4'd2,
    S_OPPEND = 4'd3,
    S_BANG   = 4'd4,
    S_IDOPEN = 4'd5,
    S_IDBODY = 4'd6,
    S_INT    = 4'd7,
    S_FRAC   = 4'd8,
    S_ERROR  = 4'd9
  } scan_mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_MARK0  = 8'hE2;
  localparam logic [7:0] CH_MARK1  = 8'h99;
  localparam logic [7:0] CH_MARK2  = 8'h82;

  function automatic logic [7:0] body_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0, 3'd1, 3'd2, 3'd3: c = CH_UA;
      3'd4:                   c = CH_UH;
      default:                c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] param_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:       c = CH_LA;
      3'd1, 3'd2: c = CH_LS;
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] marker_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_MARK0;
      3'd1:    c = CH_MARK1;
      3'd2:    c = CH_MARK2;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/sbt_front.sv */
// Front end: scans one byte per cycle while in_take is set and pushes the tokens it completes.
module sbt_front #(
  parameter int POSITION_WIDTH = sbt_pkg::POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = sbt_pkg::LENGTH_WIDTH_DEF,
  localparam int TOK_W = sbt_pkg::KIND_W + sbt_pkg::OP_W + LENGTH_WIDTH + 2 * POSITION_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output logic             push,
  output logic             push_two,
  output logic [TOK_W-1:0] push_tok0,
  output logic [TOK_W-1:0] push_tok1
);

  localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = {LENGTH_WIDTH{1'b1}};
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  sbt_pkg::scan_mode_t       mode_r, mode_nxt;
  logic [2:0]                mp_r, mp_nxt;
  logic [sbt_pkg::OP_W-1:0]  pend_r, pend_nxt;
  logic [LENGTH_WIDTH-1:0]   len_r, len_nxt;
  logic [POSITION_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [POSITION_WIDTH-1:0] line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] tline_r, tline_nxt;

  logic                      eot;
  logic                      is_dig;
  logic                      restart;
  logic                      a_v, b_v;
  logic [TOK_W-1:0]          a_tok, b_tok;
  logic [LENGTH_WIDTH-1:0]   len_inc;
  logic [2:0]                mp_new;

  function automatic logic [TOK_W-1:0] make_tok(
    input sbt_pkg::token_kind_t      kind,
    input logic [sbt_pkg::OP_W-1:0]  op,
    input logic [LENGTH_WIDTH-1:0]   len,
    input logic [POSITION_WIDTH-1:0] start,
    input logic [POSITION_WIDTH-1:0] line
  );
    return {line, start, len, op, kind};
  endfunction

  assign eot     = end_of_text || (text_byte == 8'h00);
  assign is_dig  = (text_byte >= sbt_pkg::CH_0) && (text_byte <= sbt_pkg::CH_9);
  assign len_inc = (len_r == LEN_MAX) ? len_r : len_r + LENGTH_WIDTH'(1);

  always_comb begin
    mode_nxt   = mode_r;
    mp_nxt     = mp_r;
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    tstart_nxt = tstart_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    tline_nxt  = tline_r;
    restart    = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    a_tok      = '0;
    b_tok      = '0;
    mp_new     = '0;
    if (eot) begin
      case (mode_r)
        sbt_pkg::S_OPPEND: begin
          a_v   = 1'b1;
          a_tok = make_tok(sbt_pkg::KIND_OP, pend_r, len_r, tstart_r, tline_r);
        end
        sbt_pkg::S_INT, sbt_pkg::S_FRAC: begin
          a_v   = 1'b1;
          a_tok = make_tok(sbt_pkg::KIND_NUMBER, sbt_pkg::OP_NONE, len_r, tstart_r, tline_r);
        end
        sbt_pkg::S_BODY, sbt_pkg::S_PARAM, sbt_pkg::S_BANG,
        sbt_pkg::S_IDOPEN, sbt_pkg::S_IDBODY: begin
          a_v   = 1'b1;
          a_tok = make_tok(sbt_pkg::KIND_ERROR, sbt_pkg::OP_NONE, len_r, tstart_r, tline_r);
        end
        default: begin
        end
      endcase
      b_v        = 1'b1;
      b_tok      = make_tok(sbt_pkg::KIND_END, sbt_pkg::OP_NONE, '0, pos_r, line_r);
      mode_nxt   = sbt_pkg::S_IDLE;
      mp_nxt     = '0;
      pend_nxt   = '0;
      len_nxt    = '0;
      tstart_nxt = '0;
      pos_nxt    = '0;
      line_nxt   = POSITION_WIDTH'(1);
      tline_nxt  = POSITION_WIDTH'(1);
    end else begin
      pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_WIDTH'(1);
      case (mode_r)
        sbt_pkg::S_IDLE: begin
          restart = 1'b1;
        end
        sbt_pkg::S_BODY, sbt_pkg::S_PARAM: begin
          len_nxt = len_inc;
          if ((mode_r == sbt_pkg::S_BODY && mp_r < 3'd5
               && text_byte == sbt_pkg::body_char(mp_r))
              || (mode_r == sbt_pkg::S_PARAM && mp_r < 3'd3
               && text_byte == sbt_pkg::param_char(mp_r))) begin
            mp_nxt = mp_r + 3'd1;
            if (mode_r == sbt_pkg::S_BODY && mp_r == 3'd4) begin
              a_v      = 1'b1;
              a_tok    = make_tok(sbt_pkg::KIND_BODY, sbt_pkg::OP_NONE, len_inc,
                                  tstart_r, tline_r);
              mode_nxt = sbt_pkg::S_IDLE;
            end else if (mode_r == sbt_pkg::S_PARAM && mp_r == 3'd2) begin
              a_v      = 1'b1;
              a_tok    = make_tok(sbt_pkg::KIND_PARAM, sbt_pkg::OP_NONE, len_inc,
                                  tstart_r, tline_r);
              mode_nxt = sbt_pkg::S_IDLE;
            end
          end else begin
            a_v      = 1'b1;
            a_tok    = make_tok(sbt_pkg::KIND_ERROR, sbt_pkg::OP_NONE, len_inc,
                                tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_ERROR;
          end
        end
        sbt_pkg::S_OPPEND: begin
          a_v      = 1'b1;
          mode_nxt = sbt_pkg::S_IDLE;
          if (text_byte == sbt_pkg::CH_EQ) begin
            len_nxt = len_inc;
            // two-byte form directly follows its one-byte code
            a_tok   = make_tok(sbt_pkg::KIND_OP, pend_r + 4'd1, len_inc, tstart_r, tline_r);
          end else begin
            a_tok   = make_tok(sbt_pkg::KIND_OP, pend_r, len_r, tstart_r, tline_r);
            restart = 1'b1;
          end
        end
        sbt_pkg::S_BANG: begin
          len_nxt = len_inc;
          a_v     = 1'b1;
          if (text_byte == sbt_pkg::CH_EQ) begin
            a_tok    = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_NE, len_inc, tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_IDLE;
          end else begin
            a_tok    = make_tok(sbt_pkg::KIND_ERROR, sbt_pkg::OP_NONE, len_inc,
                                tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_ERROR;
          end
        end
        sbt_pkg::S_IDOPEN: begin
          len_nxt = len_inc;
          if (mp_r < 3'd3 && text_byte == sbt_pkg::marker_char(mp_r)) begin
            mp_nxt = mp_r + 3'd1;
            if (mp_r == 3'd2) begin
              mode_nxt = sbt_pkg::S_IDBODY;
              mp_nxt   = '0;
            end
          end else begin
            a_v      = 1'b1;
            a_tok    = make_tok(sbt_pkg::KIND_ERROR, sbt_pkg::OP_NONE, len_inc,
                                tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_ERROR;
          end
        end
        sbt_pkg::S_IDBODY: begin
          len_nxt = len_inc;
          if (mp_r < 3'd3 && text_byte == sbt_pkg::marker_char(mp_r)) begin
            mp_new = mp_r + 3'd1;
          end else if (text_byte == sbt_pkg::CH_MARK0) begin
            mp_new = 3'd1;
          end else begin
            mp_new = 3'd0;
          end
          mp_nxt = mp_new;
          if (mp_new == 3'd3) begin
            a_v      = 1'b1;
            a_tok    = make_tok(sbt_pkg::KIND_IDENT, sbt_pkg::OP_NONE, len_inc,
                                tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_IDLE;
            mp_nxt   = '0;
          end
        end
        sbt_pkg::S_INT, sbt_pkg::S_FRAC: begin
          if (is_dig) begin
            len_nxt = len_inc;
          end else if (mode_r == sbt_pkg::S_INT && text_byte == sbt_pkg::CH_DOT) begin
            len_nxt  = len_inc;
            mode_nxt = sbt_pkg::S_FRAC;
          end else begin
            a_v      = 1'b1;
            a_tok    = make_tok(sbt_pkg::KIND_NUMBER, sbt_pkg::OP_NONE, len_r,
                                tstart_r, tline_r);
            mode_nxt = sbt_pkg::S_IDLE;
            restart  = 1'b1;
          end
        end
        sbt_pkg::S_ERROR: begin
        end
        default: begin
          mode_nxt = sbt_pkg::S_ERROR;
        end
      endcase
      if (restart) begin
        if (text_byte == sbt_pkg::CH_LF) begin
          line_nxt = (line_r == POS_MAX) ? line_r : line_r + POSITION_WIDTH'(1);
        end else if (!(text_byte == sbt_pkg::CH_SPACE || text_byte == sbt_pkg::CH_TAB
                       || text_byte == sbt_pkg::CH_CR)) begin
          tstart_nxt = pos_r;
          tline_nxt  = line_r;
          len_nxt    = LENGTH_WIDTH'(1);
          mp_nxt     = '0;
          case (text_byte)
            sbt_pkg::CH_DOLLAR: begin
              b_v   = 1'b1;
              b_tok = make_tok(sbt_pkg::KIND_DOLLAR, sbt_pkg::OP_NONE, LENGTH_WIDTH'(1),
                               pos_r, line_r);
            end
            sbt_pkg::CH_UA: begin
              mode_nxt = sbt_pkg::S_BODY;
              mp_nxt   = 3'd1;
            end
            sbt_pkg::CH_LA: begin
              mode_nxt = sbt_pkg::S_PARAM;
              mp_nxt   = 3'd1;
            end
            sbt_pkg::CH_PLUS, sbt_pkg::CH_MINUS, sbt_pkg::CH_STAR, sbt_pkg::CH_SLASH,
            sbt_pkg::CH_CARET, sbt_pkg::CH_LPAR, sbt_pkg::CH_RPAR: begin
              b_v = 1'b1;
              case (text_byte)
                sbt_pkg::CH_PLUS:  b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_PLUS,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                sbt_pkg::CH_MINUS: b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_MINUS,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                sbt_pkg::CH_STAR:  b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_STAR,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                sbt_pkg::CH_SLASH: b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_SLASH,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                sbt_pkg::CH_CARET: b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_CARET,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                sbt_pkg::CH_LPAR:  b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_LPAR,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
                default:           b_tok = make_tok(sbt_pkg::KIND_OP, sbt_pkg::OP_RPAR,
                                                    LENGTH_WIDTH'(1), pos_r, line_r);
              endcase
            end
            sbt_pkg::CH_EQ: begin
              mode_nxt = sbt_pkg::S_OPPEND;
              pend_nxt = sbt_pkg::OP_ASSIGN;
            end
            sbt_pkg::CH_LT: begin
              mode_nxt = sbt_pkg::S_OPPEND;
              pend_nxt = sbt_pkg::OP_LT;
            end
            sbt_pkg::CH_GT: begin
              mode_nxt = sbt_pkg::S_OPPEND;
              pend_nxt = sbt_pkg::OP_GT;
            end
            sbt_pkg::CH_BANG: begin
              mode_nxt = sbt_pkg::S_BANG;
            end
            sbt_pkg::CH_MARK0: begin
              mode_nxt = sbt_pkg::S_IDOPEN;
              mp_nxt   = 3'd1;
            end
            default: begin
              if (is_dig) begin
                mode_nxt = sbt_pkg::S_INT;
              end else begin
                b_v      = 1'b1;
                b_tok    = make_tok(sbt_pkg::KIND_ERROR, sbt_pkg::OP_NONE, LENGTH_WIDTH'(1),
                                    pos_r, line_r);
                mode_nxt = sbt_pkg::S_ERROR;
              end
            end
          endcase
        end
      end
    end
  end

  assign push      = in_take && (a_v || b_v);
  assign push_two  = a_v && b_v;
  assign push_tok0 = a_v ? a_tok : b_tok;
  assign push_tok1 = b_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sbt_pkg::S_IDLE;
      mp_r     <= '0;
      pend_r   <= '0;
      len_r    <= '0;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= POSITION_WIDTH'(1);
      tline_r  <= POSITION_WIDTH'(1);
    end else if (in_take) begin
      mode_r   <= mode_nxt;
      mp_r     <= mp_nxt;
      pend_r   <= pend_nxt;
      len_r    <= len_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tline_r  <= tline_nxt;
    end
  end

endmodule

/* design/sbt_queue.sv */
// Short token queue between the scanner and the output stage.
module sbt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sbt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == CNT_W'(0));
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/sbt_back.sv */
// Back end: splits queued token pairs into single items in the output register.
module sbt_back #(
  parameter int TOK_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [2*TOK_W:0] q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [TOK_W-1:0] out_tok,
  output logic             out_last
);

  logic             valid_r, valid_nxt;
  logic             phase_r, phase_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  logic             last_r, last_nxt;
  logic             load;
  logic             two;

  assign two  = q_head[2*TOK_W];
  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        tok_nxt   = phase_r ? q_head[2*TOK_W-1:TOK_W] : q_head[TOK_W-1:0];
        last_nxt  = phase_r || !two;
        q_pop     = last_nxt;
        phase_nxt = !last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

/* design/source_byte_tokenizer_top.sv */
// Top level of the source byte tokenizer: scanner, token queue and output stage.
// Takes one source byte per cycle on the input stream and keeps that pace as long as the
// output side takes one item per cycle: the scanner settles each byte combinationally
// and hands the zero, one or two tokens it completes to a four-entry queue, and the output
// stage sends one token per cycle from its register while out_tready holds, so the two
// tokens of one byte leave as separate items and the queue absorbs the backlog. A token
// passes through a queue slot and then the output register. A set in_tlast, or a zero
// byte, ends the text: any open token is closed, an end token follows with tlast set,
// and counters restart. Lengths, offsets and line numbers saturate at their maximum.
module source_byte_tokenizer_top #(
  parameter int POSITION_WIDTH = sbt_pkg::POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = sbt_pkg::LENGTH_WIDTH_DEF,
  localparam int TOK_W   = sbt_pkg::KIND_W + sbt_pkg::OP_W + LENGTH_WIDTH
                           + 2 * POSITION_WIDTH,
  localparam int TDATA_W = ((TOK_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // text_byte
  input  logic               in_tlast,   // end_of_text
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // token_kind, operator_code, token_length,
                                         // start_offset, line_number, zero pad
  output logic               out_tlast   // last
);

  localparam int QW = 2 * TOK_W + 1;

  logic             in_take;
  logic             push, push_two;
  logic [TOK_W-1:0] push_tok0, push_tok1;
  logic             q_full, q_empty, q_pop;
  logic [QW-1:0]    q_head;
  logic [TOK_W-1:0] out_tok;

  assign in_tready = !q_full;
  assign in_take   = in_tvalid && in_tready;

  sbt_front #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .text_byte  (in_tdata),
    .end_of_text(in_tlast),
    .push       (push),
    .push_two   (push_two),
    .push_tok0  (push_tok0),
    .push_tok1  (push_tok1)
  );

  sbt_queue #(
    .WIDTH(QW),
    .DEPTH(sbt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_two, push_tok1, push_tok0}),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sbt_back #(
    .TOK_W(TOK_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_tok  (out_tok),
    .out_last (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_tok);

  localparam int LEN_LO  = sbt_pkg::KIND_W + sbt_pkg::OP_W;
  localparam int LINE_LO = LEN_LO + LENGTH_WIDTH + POSITION_WIDTH;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tok[2:0] == sbt_pkg::KIND_END |-> out_tlast)
    else $error("end token without tlast");

  a_op_only_on_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tok[2:0] != sbt_pkg::KIND_OP |-> out_tok[6:3] == sbt_pkg::OP_NONE)
    else $error("operator code on a non-operator token");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tok[2:0] != sbt_pkg::KIND_END
    |-> out_tok[LEN_LO+LENGTH_WIDTH-1:LEN_LO] != '0)
    else $error("empty token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tok[LINE_LO+POSITION_WIDTH-1:LINE_LO] != '0)
    else $error("line number zero");

endmodule
